### rtl/grid_flood_fill_region_keeper_top_assert.svh
// assertion macros for the region keeper
`ifndef GRID_FLOOD_FILL_REGION_KEEPER_TOP_ASSERT_SVH
`define GRID_FLOOD_FILL_REGION_KEEPER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define GFFRK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define GFFRK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gffrk_pkg.sv
// shared types and constants of the region keeper
package gffrk_pkg;

    localparam int COORD_W   = 8;
    localparam int CFG_W     = 7;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 13;
    localparam int CMD_W     = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEED_X      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEED_Y      = 3'd3;

    // register reset values
    localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [POS_W-1:0] SEED_RST      = 6'd32;

    typedef logic [COORD_W-1:0] coord_t;

    // neighbor selection, self used for plain tile checks
    typedef enum logic [2:0] {
        DIR_XP   = 3'd0,
        DIR_XN   = 3'd1,
        DIR_YP   = 3'd2,
        DIR_YN   = 3'd3,
        DIR_SELF = 3'd4
    } dir_t;

    typedef struct packed {
        coord_t nx;
        coord_t ny;
        logic   in_grid;
    } nbr_t;

endpackage

### rtl/gffrk_ram.sv
// generic single write, single registered read memory
module gffrk_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gffrk_nbr_unit.sv
// shared neighbor step and grid range compare
module gffrk_nbr_unit (
    input  gffrk_pkg::coord_t base_x,
    input  gffrk_pkg::coord_t base_y,
    input  gffrk_pkg::dir_t   dir,
    input  gffrk_pkg::coord_t eff_w,
    input  gffrk_pkg::coord_t eff_h,
    output gffrk_pkg::nbr_t   nbr
);
    import gffrk_pkg::*;

    coord_t nx;
    coord_t ny;

    // step one tile; a step below zero wraps high and fails the range test
    always_comb
    begin
        nx = base_x;
        ny = base_y;
        case (dir)
            DIR_XP: nx = base_x + coord_t'(1);
            DIR_XN: nx = base_x - coord_t'(1);
            DIR_YP: ny = base_y + coord_t'(1);
            DIR_YN: ny = base_y - coord_t'(1);
            default: ;
        endcase
    end

    assign nbr.nx      = nx;
    assign nbr.ny      = ny;
    assign nbr.in_grid = (nx < eff_w) && (ny < eff_h);

endmodule

### rtl/grid_flood_fill_region_keeper_top.sv
// region keeper top: tile map, flood fill sequencer and wall-off sweep
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, command..wall_in       beat into block
//  out       out_valid/out_ready, tile_wall, count     beat out of block
//  cfg       cfg_we, cfg_index, cfg_data               register write
//
// a write or unknown command answers from the idle state, a read after the memory read;
// a fill checks the seed, then pops each reached tile and checks its four neighbors
// in turn, then sweeps every cell; the neighbor unit and the single read port of each
// memory set the loop; after reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// (pow2 rounded) cells clears the visited map; no beat is taken meanwhile
// a waiting result holds off the next beat until it is taken
module grid_flood_fill_region_keeper_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gffrk_pkg::CMD_W-1:0]       command,
    input  logic [gffrk_pkg::POS_W-1:0]       tile_col,
    input  logic [gffrk_pkg::POS_W-1:0]       tile_row,
    input  logic                              wall_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              tile_wall,
    output logic [gffrk_pkg::COUNT_W-1:0]     reachable_tiles,
    input  logic                              cfg_we,
    input  logic [gffrk_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [gffrk_pkg::CFG_W-1:0]       cfg_data
);
    import gffrk_pkg::*;

    `include "grid_flood_fill_region_keeper_top_assert.svh"

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = 1 << AW;
    localparam int DW    = AW + 1;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_NREQ  = 9'b000001000,
        ST_NCHK  = 9'b000010000,
        ST_POP   = 9'b000100000,
        ST_POPW  = 9'b001000000,
        ST_SWEEP = 9'b010000000,
        ST_SWEND = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     grid_width_reg, grid_width_next;
    logic [CFG_W-1:0]     grid_height_reg, grid_height_next;
    logic [POS_W-1:0]     seed_x_reg, seed_x_next;
    logic [POS_W-1:0]     seed_y_reg, seed_y_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [COUNT_W-1:0]   reached_count_reg, reached_count_next;
    logic [AW-1:0]        sweep_addr_reg, sweep_addr_next;
    logic                 sw_pend_reg, sw_pend_next;
    logic                 out_valid_reg, out_valid_next;

    coord_t               base_x_reg, base_x_next;
    coord_t               base_y_reg, base_y_next;
    dir_t                 dir_reg, dir_next;
    logic [AW-1:0]        nb_addr_reg, nb_addr_next;
    logic                 nb_in_reg, nb_in_next;
    logic                 rd_in_reg, rd_in_next;
    logic [AW-1:0]        sw_addr_reg, sw_addr_next;
    logic                 out_wall_reg, out_wall_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic                 in_fire;
    logic                 out_fire;
    coord_t               eff_w;
    coord_t               eff_h;
    coord_t               unit_x;
    coord_t               unit_y;
    dir_t                 unit_dir;
    nbr_t                 nbr;
    logic [AW-1:0]        nbr_addr;
    logic [DW-1:0]        depth_m1;
    coord_t               sx;
    coord_t               sy;
    logic [COORD_W:0]     sx_p1;
    logic [COORD_W:0]     sy_p1;
    logic                 sw_interior;

    logic                 tile_we;
    logic [AW-1:0]        tile_wa;
    logic [0:0]           tile_wd;
    logic [AW-1:0]        tile_ra;
    logic [0:0]           tile_rdata;
    logic                 vis_we;
    logic [AW-1:0]        vis_wa;
    logic [0:0]           vis_wd;
    logic [AW-1:0]        vis_ra;
    logic [0:0]           vis_rdata;
    logic                 stk_we;
    logic [AW-1:0]        stk_wa;
    logic [AW-1:0]        stk_wd;
    logic [AW-1:0]        stk_ra;
    logic [AW-1:0]        stk_rdata;

    // handshakes
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign out_valid       = out_valid_reg;
    assign tile_wall       = out_wall_reg;
    assign reachable_tiles = out_count_reg;

    // grid size in use, limited to the storage
    assign eff_w = ((COORD_W+1)'(grid_width_reg) > (COORD_W+1)'(MAX_WIDTH))
                 ? coord_t'(MAX_WIDTH) : coord_t'(grid_width_reg);
    assign eff_h = ((COORD_W+1)'(grid_height_reg) > (COORD_W+1)'(MAX_HEIGHT))
                 ? coord_t'(MAX_HEIGHT) : coord_t'(grid_height_reg);

    // neighbor unit operands: the beat's tile when idle, else the fill cursor
    assign unit_x   = (state_reg == ST_IDLE) ? coord_t'(tile_col) : base_x_reg;
    assign unit_y   = (state_reg == ST_IDLE) ? coord_t'(tile_row) : base_y_reg;
    assign unit_dir = (state_reg == ST_IDLE) ? DIR_SELF : dir_reg;

    gffrk_nbr_unit u_nbr (
        .base_x (unit_x),
        .base_y (unit_y),
        .dir    (unit_dir),
        .eff_w  (eff_w),
        .eff_h  (eff_h),
        .nbr    (nbr)
    );

    assign nbr_addr = {nbr.ny[YW-1:0], nbr.nx[XW-1:0]};
    assign depth_m1 = depth_reg - DW'(1);

    // interior test of the tile being swept
    assign sx          = coord_t'(sw_addr_reg[XW-1:0]);
    assign sy          = coord_t'(sw_addr_reg[AW-1:XW]);
    assign sx_p1       = (COORD_W+1)'(sx) + (COORD_W+1)'(1);
    assign sy_p1       = (COORD_W+1)'(sy) + (COORD_W+1)'(1);
    assign sw_interior = (sx != '0) && (sy != '0)
                      && (sx_p1 < (COORD_W+1)'(eff_w))
                      && (sy_p1 < (COORD_W+1)'(eff_h));

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        grid_width_next    = grid_width_reg;
        grid_height_next   = grid_height_reg;
        seed_x_next        = seed_x_reg;
        seed_y_next        = seed_y_reg;
        depth_next         = depth_reg;
        reached_count_next = reached_count_reg;
        sweep_addr_next    = sweep_addr_reg;
        sw_pend_next       = sw_pend_reg;
        out_valid_next     = out_valid_reg;
        base_x_next        = base_x_reg;
        base_y_next        = base_y_reg;
        dir_next           = dir_reg;
        nb_addr_next       = nb_addr_reg;
        nb_in_next         = nb_in_reg;
        rd_in_next         = rd_in_reg;
        sw_addr_next       = sw_addr_reg;
        out_wall_next      = out_wall_reg;
        out_count_next     = out_count_reg;

        tile_we = 1'b0;
        tile_wa = nbr_addr;
        tile_wd = wall_in;
        tile_ra = nbr_addr;
        vis_we  = 1'b0;
        vis_wa  = nb_addr_reg;
        vis_wd  = 1'b0;
        vis_ra  = nbr_addr;
        stk_we  = 1'b0;
        stk_wa  = depth_reg[AW-1:0];
        stk_wd  = nb_addr_reg;
        stk_ra  = depth_m1[AW-1:0];

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_next  = cfg_data;
                REG_GRID_HEIGHT: grid_height_next = cfg_data;
                REG_SEED_X:      seed_x_next      = cfg_data[POS_W-1:0];
                REG_SEED_Y:      seed_y_next      = cfg_data[POS_W-1:0];
                default: ;
            endcase
        end

        // pending sweep write: wall off unreached open interior, clear visited
        if (sw_pend_reg && (state_reg == ST_SWEEP || state_reg == ST_SWEND))
        begin
            vis_we  = 1'b1;
            vis_wa  = sw_addr_reg;
            vis_wd  = 1'b0;
            tile_we = sw_interior && !tile_rdata[0] && !vis_rdata[0];
            tile_wa = sw_addr_reg;
            tile_wd = 1'b1;
        end

        case (state_reg)
            ST_INIT:
            begin
                vis_we          = 1'b1;
                vis_wa          = sweep_addr_reg;
                vis_wd          = 1'b0;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (&sweep_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (command)
                        CMD_WRITE:
                        begin
                            tile_we        = nbr.in_grid;
                            out_valid_next = 1'b1;
                            out_wall_next  = 1'b0;
                            out_count_next = reached_count_reg;
                        end
                        CMD_FILL:
                        begin
                            base_x_next        = coord_t'(seed_x_reg);
                            base_y_next        = coord_t'(seed_y_reg);
                            dir_next           = DIR_SELF;
                            depth_next         = '0;
                            reached_count_next = '0;
                            state_next         = ST_NREQ;
                        end
                        CMD_READ:
                        begin
                            rd_in_next = nbr.in_grid;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_wall_next  = 1'b0;
                            out_count_next = reached_count_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_wall_next  = !rd_in_reg || tile_rdata[0];
                out_count_next = reached_count_reg;
                state_next     = ST_IDLE;
            end
            ST_NREQ:
            begin
                nb_addr_next = nbr_addr;
                nb_in_next   = nbr.in_grid;
                state_next   = ST_NCHK;
            end
            ST_NCHK:
            begin
                // open and unseen: mark and push
                if (nb_in_reg && !tile_rdata[0] && !vis_rdata[0])
                begin
                    vis_we     = 1'b1;
                    vis_wa     = nb_addr_reg;
                    vis_wd     = 1'b1;
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                case (dir_reg)
                    DIR_XP:
                    begin
                        dir_next   = DIR_XN;
                        state_next = ST_NREQ;
                    end
                    DIR_XN:
                    begin
                        dir_next   = DIR_YP;
                        state_next = ST_NREQ;
                    end
                    DIR_YP:
                    begin
                        dir_next   = DIR_YN;
                        state_next = ST_NREQ;
                    end
                    default:
                    begin
                        state_next = ST_POP;
                    end
                endcase
            end
            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    sweep_addr_next = '0;
                    sw_pend_next    = 1'b0;
                    state_next      = ST_SWEEP;
                end
                else
                begin
                    depth_next = depth_m1;
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                base_x_next = coord_t'(stk_rdata[XW-1:0]);
                base_y_next = coord_t'(stk_rdata[AW-1:XW]);
                if (reached_count_reg != COUNT_MAX)
                begin
                    reached_count_next = reached_count_reg + COUNT_W'(1);
                end
                dir_next   = DIR_XP;
                state_next = ST_NREQ;
            end
            ST_SWEEP:
            begin
                tile_ra         = sweep_addr_reg;
                vis_ra          = sweep_addr_reg;
                sw_addr_next    = sweep_addr_reg;
                sw_pend_next    = 1'b1;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (&sweep_addr_reg)
                begin
                    state_next = ST_SWEND;
                end
            end
            ST_SWEND:
            begin
                sw_pend_next   = 1'b0;
                out_valid_next = 1'b1;
                out_wall_next  = 1'b0;
                out_count_next = reached_count_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            grid_width_reg    <= GRID_SIZE_RST;
            grid_height_reg   <= GRID_SIZE_RST;
            seed_x_reg        <= SEED_RST;
            seed_y_reg        <= SEED_RST;
            depth_reg         <= '0;
            reached_count_reg <= '0;
            sweep_addr_reg    <= '0;
            sw_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            grid_width_reg    <= grid_width_next;
            grid_height_reg   <= grid_height_next;
            seed_x_reg        <= seed_x_next;
            seed_y_reg        <= seed_y_next;
            depth_reg         <= depth_next;
            reached_count_reg <= reached_count_next;
            sweep_addr_reg    <= sweep_addr_next;
            sw_pend_reg       <= sw_pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_x_reg    <= base_x_next;
        base_y_reg    <= base_y_next;
        dir_reg       <= dir_next;
        nb_addr_reg   <= nb_addr_next;
        nb_in_reg     <= nb_in_next;
        rd_in_reg     <= rd_in_next;
        sw_addr_reg   <= sw_addr_next;
        out_wall_reg  <= out_wall_next;
        out_count_reg <= out_count_next;
    end

    // tile map
    gffrk_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_wa),
        .wdata (tile_wd),
        .raddr (tile_ra),
        .rdata (tile_rdata)
    );

    // visited map
    gffrk_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_wa),
        .wdata (vis_wd),
        .raddr (vis_ra),
        .rdata (vis_rdata)
    );

    // pending tile stack
    gffrk_ram #(
        .WIDTH (AW),
        .DEPTH (CELLS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_wa),
        .wdata (stk_wd),
        .raddr (stk_ra),
        .rdata (stk_rdata)
    );

    // checks
    `GFFRK_ASSERT_NEXT(a_fill_start, in_fire && command == CMD_FILL, state_reg == ST_NREQ && reached_count_reg == '0 && depth_reg == '0, "fill did not start clean")
    `GFFRK_ASSERT_NEXT(a_empty_stack_sweeps, state_reg == ST_POP && depth_reg == '0, state_reg == ST_SWEEP, "empty stack did not start sweep")
    `GFFRK_ASSERT_SAME(a_no_result_mid_fill, state_reg == ST_NREQ || state_reg == ST_NCHK || state_reg == ST_POP || state_reg == ST_POPW || state_reg == ST_SWEEP, !out_valid_reg, "result shown during fill")
    `GFFRK_ASSERT_SAME(a_push_bounded, stk_we, state_reg == ST_NCHK && depth_reg < DW'(CELLS), "stack push out of bounds")
    `GFFRK_ASSERT_NEXT(a_pop_counts, state_reg == ST_POPW, reached_count_reg != '0, "popped tile not counted")

endmodule
